FILE: rtl/core/gslema_pkg.sv
`timescale 1ns / 1ps

package gslema_pkg;

  localparam int GAIN_W     = 16;
  localparam int CAP_W      = 23;
  localparam int CONF_W     = 16;
  localparam int LIMIT_W    = 23;
  localparam int CFG_DATA_W = 23;
  localparam int CFG_ADDR_W = 2;
  localparam int CNT_W      = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_GAIN  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_CAP   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_FLOOR = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_LIMIT = 2'd3;

  // Defaults: alpha 0.3, 20 ms slew cap, confidence 2.0, 500 ms alarm.
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd19661;
  localparam logic [CAP_W-1:0]   CAP_RST   = 23'd5120;
  localparam logic [CONF_W-1:0]  FLOOR_RST = 16'd512;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 23'd128000;

  localparam logic [CNT_W-1:0] READY_COUNT = 2'd3;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [CAP_W-1:0]   cap;
    logic [CONF_W-1:0]  floor;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_NOT_READY = 2'd0,
    ST_LOCKED    = 2'd1,
    ST_DEGRADED  = 2'd2
  } lock_status_t;

endpackage

FILE: rtl/core/gslema_if.sv
`timescale 1ns / 1ps

interface gslema_in_if #(
  parameter int OFFSET_BITS = 24
) ();
  logic                                 valid;
  logic                                 ready;
  logic signed [OFFSET_BITS-1:0]        raw_offset;
  logic [gslema_pkg::CONF_W-1:0]        confidence;
  logic                                 sample_invalid;

  modport source (output valid, raw_offset, confidence, sample_invalid, input ready);
  modport sink   (input valid, raw_offset, confidence, sample_invalid, output ready);
endinterface

interface gslema_out_if #(
  parameter int OFFSET_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic signed [OFFSET_BITS-1:0] smoothed_offset;
  logic [1:0]                    lock_status;

  modport source (output valid, accepted, smoothed_offset, lock_status, input ready);
  modport sink   (input valid, accepted, smoothed_offset, lock_status, output ready);
endinterface

FILE: rtl/core/gslema_cfg.sv
`timescale 1ns / 1ps

module gslema_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gslema_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [gslema_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output gslema_pkg::cfg_t                    cfg
);

  gslema_pkg::cfg_t cfg_r;
  gslema_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        gslema_pkg::CFG_IDX_GAIN:  cfg_nxt.gain  = cfg_wdata[gslema_pkg::GAIN_W-1:0];
        gslema_pkg::CFG_IDX_CAP:   cfg_nxt.cap   = cfg_wdata[gslema_pkg::CAP_W-1:0];
        gslema_pkg::CFG_IDX_FLOOR: cfg_nxt.floor = cfg_wdata[gslema_pkg::CONF_W-1:0];
        gslema_pkg::CFG_IDX_LIMIT: cfg_nxt.limit = cfg_wdata[gslema_pkg::LIMIT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain  <= gslema_pkg::GAIN_RST;
      cfg_r.cap   <= gslema_pkg::CAP_RST;
      cfg_r.floor <= gslema_pkg::FLOOR_RST;
      cfg_r.limit <= gslema_pkg::LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/gslema_core.sv
`timescale 1ns / 1ps

module gslema_core #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  gslema_pkg::cfg_t                     cfg,
  input  logic                                 fire,
  input  logic signed [OFFSET_BITS-1:0]        raw_offset,
  input  logic [gslema_pkg::CONF_W-1:0]        confidence,
  input  logic                                 sample_invalid,
  output logic                                 res_accepted,
  output logic signed [OFFSET_BITS-1:0]        res_smoothed,
  output gslema_pkg::lock_status_t             res_status
);

  localparam int W    = OFFSET_BITS;
  localparam int DW   = W + 1;
  localparam int PW   = DW + gslema_pkg::GAIN_W + 1;
  localparam int SW   = (W + 2 > gslema_pkg::CAP_W + 1) ? W + 2 : gslema_pkg::CAP_W + 1;
  localparam int SUMW = SW + 1;
  localparam int MW   = (W + 1 > gslema_pkg::LIMIT_W) ? W + 1 : gslema_pkg::LIMIT_W;

  logic signed [W-1:0]                    smooth_r, smooth_nxt;
  logic [gslema_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [gslema_pkg::CONF_W-1:0]          lconf_r, lconf_nxt;

  logic signed [DW-1:0]   diff;
  logic signed [PW-1:0]   prod;
  logic signed [SW-1:0]   step, step_c, cap_s;
  logic signed [SUMW-1:0] sum;
  logic signed [W-1:0]    sat;
  logic                   ovf;
  logic [W:0]             mag;
  logic                   upd, take;

  assign upd  = fire && !sample_invalid;
  assign take = upd && (confidence >= cfg.floor);

  assign diff = DW'(raw_offset) - DW'(smooth_r);
  assign prod = diff * $signed({1'b0, cfg.gain});
  // Dropping the low 16 bits of a two's complement product floors toward minus infinity.
  assign step  = SW'($signed(prod[PW-1:16]));
  assign cap_s = $signed(SW'(cfg.cap));

  always_comb begin
    if (step > cap_s) begin
      step_c = cap_s;
    end else if (step < -cap_s) begin
      step_c = -cap_s;
    end else begin
      step_c = step;
    end
  end

  assign sum = SUMW'(smooth_r) + SUMW'(step_c);
  // Overflow when the bits above the result's sign are not all copies of it.
  assign ovf = !((&sum[SUMW-1:W-1]) || !(|sum[SUMW-1:W-1]));
  assign sat = ovf ? (sum[SUMW-1] ? $signed({1'b1, {(W-1){1'b0}}})
                                  : $signed({1'b0, {(W-1){1'b1}}}))
                   : sum[W-1:0];

  always_comb begin
    smooth_nxt = take ? sat : smooth_r;
    cnt_nxt    = (take && (cnt_r != gslema_pkg::READY_COUNT)) ? cnt_r + 2'd1 : cnt_r;
    lconf_nxt  = upd ? confidence : lconf_r;
  end

  assign mag = smooth_nxt[W-1] ? (W+1)'(-(W+1)'(smooth_nxt)) : (W+1)'(smooth_nxt);

  always_comb begin
    if (cnt_nxt != gslema_pkg::READY_COUNT) begin
      res_status = gslema_pkg::ST_NOT_READY;
    end else if ((lconf_nxt < cfg.floor) || (MW'(mag) > MW'(cfg.limit))) begin
      res_status = gslema_pkg::ST_DEGRADED;
    end else begin
      res_status = gslema_pkg::ST_LOCKED;
    end
  end

  assign res_accepted = take;
  assign res_smoothed = smooth_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= '0;
      cnt_r    <= '0;
      lconf_r  <= '0;
    end else if (fire) begin
      smooth_r <= smooth_nxt;
      cnt_r    <= cnt_nxt;
      lconf_r  <= lconf_nxt;
    end
  end

  a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> cnt_r >= $past(cnt_r))
    else $error("update count went backwards");

  a_invalid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && sample_invalid |=> $stable(smooth_r) && $stable(cnt_r) && $stable(lconf_r))
    else $error("invalid word changed state");

  a_status_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    res_status != gslema_pkg::ST_NOT_READY |-> cnt_nxt == gslema_pkg::READY_COUNT)
    else $error("status reported before enough updates");

  a_reject_holds_offset: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !res_accepted |=> $stable(smooth_r))
    else $error("smoothed offset moved without an accepted word");

endmodule

FILE: rtl/core/gated_slew_limited_ema_smoother.sv
`timescale 1ns / 1ps

// Smooths a stream of offset measurements with a confidence-gated exponential
// moving average whose step is limited to a programmable slew cap. Every input
// word yields exactly one result word carrying the accept flag, the smoothed
// offset and the lock status. A word is registered on input; its full update
// (multiply by alpha, clamp, saturating add, status) goes into the output
// register once it is free, so a new word can be taken every cycle while the
// output is not stalled; the state feedback through the single update stage is
// what sets the one-word-per-cycle rate. The user must write configuration
// on the cfg_ port only while no words are in flight; it is not enforced.
module gated_slew_limited_ema_smoother #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  gslema_in_if.sink                          in_ch,
  gslema_out_if.source                       out_ch,
  input  logic                               cfg_we,
  input  logic [gslema_pkg::CFG_ADDR_W-1:0]  cfg_index,
  input  logic [gslema_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  gslema_pkg::cfg_t cfg;

  logic                               in_valid_r;
  logic signed [OFFSET_BITS-1:0]      raw_r;
  logic [gslema_pkg::CONF_W-1:0]      conf_r;
  logic                               inv_r;

  logic                               out_valid_r;
  logic                               acc_r;
  logic signed [OFFSET_BITS-1:0]      smooth_out_r;
  logic [1:0]                         status_r;

  logic                               advance;
  logic                               fire;
  logic                               res_accepted;
  logic signed [OFFSET_BITS-1:0]      res_smoothed;
  gslema_pkg::lock_status_t           res_status;

  gslema_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The output register frees up when empty or when its word is taken.
  assign advance     = !out_valid_r || out_ch.ready;
  assign fire        = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;

  gslema_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .fire           (fire),
    .raw_offset     (raw_r),
    .confidence     (conf_r),
    .sample_invalid (inv_r),
    .res_accepted   (res_accepted),
    .res_smoothed   (res_smoothed),
    .res_status     (res_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      raw_r  <= in_ch.raw_offset;
      conf_r <= in_ch.confidence;
      inv_r  <= in_ch.sample_invalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      acc_r        <= res_accepted;
      smooth_out_r <= res_smoothed;
      status_r     <= res_status;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.accepted        = acc_r;
  assign out_ch.smoothed_offset = smooth_out_r;
  assign out_ch.lock_status     = status_r;

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> in_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled without output backpressure");

  a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed word did not reach the output register");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> status_r != 2'd3)
    else $error("undefined lock status on output");

endmodule

FILE: tb/gslema_output_checker.sv
`timescale 1ns / 1ps

module gslema_output_checker #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  gslema_in_if                              in_ch,
  gslema_out_if                             out_ch,
  input  logic                              cfg_we,
  input  logic [gslema_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [gslema_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                mismatch_count,
  output int                                pending_results,
  output int                                checked_results
);
  import gslema_pkg::*;

  localparam longint OFF_MAX = (longint'(1) <<< (OFFSET_BITS - 1)) - 1;
  localparam longint OFF_MIN = -OFF_MAX - 1;

  typedef struct packed {
    logic                          accepted;
    logic signed [OFFSET_BITS-1:0] offset;
    lock_status_t                  status;
  } ema_word_t;

  cfg_t                          regs_q;
  logic signed [OFFSET_BITS-1:0] smooth_q;
  logic [CNT_W-1:0]              updates_q;
  logic [CONF_W-1:0]             last_conf_q;
  ema_word_t                     predicted_words[$];
  int                            mismatches = 0;
  int                            results_seen = 0;

  // Applies one input word to the tracked filter state and returns the word
  // the block should emit for it.
  function automatic ema_word_t smooth_word(input logic signed [OFFSET_BITS-1:0] raw,
                                            input logic [CONF_W-1:0] conf,
                                            input logic inv);
    ema_word_t res;
    longint    diff;
    longint    step;
    longint    cap;
    longint    sum;
    longint    mag;
    res.accepted = 1'b0;
    if (!inv) begin
      last_conf_q = conf;
      if (conf >= regs_q.floor) begin
        diff = longint'(raw) - longint'(smooth_q);
        // Arithmetic shift of the signed product rounds toward minus infinity.
        step = (diff * longint'(regs_q.gain)) >>> 16;
        cap  = longint'(regs_q.cap);
        if (step > cap) begin
          step = cap;
        end else if (step < -cap) begin
          step = -cap;
        end
        sum = longint'(smooth_q) + step;
        if (sum > OFF_MAX) begin
          sum = OFF_MAX;
        end else if (sum < OFF_MIN) begin
          sum = OFF_MIN;
        end
        smooth_q = sum[OFFSET_BITS-1:0];
        if (updates_q < READY_COUNT) begin
          updates_q = updates_q + 1'b1;
        end
        res.accepted = 1'b1;
      end
    end
    mag = (smooth_q < 0) ? -longint'(smooth_q) : longint'(smooth_q);
    res.offset = smooth_q;
    if (updates_q < READY_COUNT) begin
      res.status = ST_NOT_READY;
    end else if (last_conf_q < regs_q.floor || mag > longint'(regs_q.limit)) begin
      res.status = ST_DEGRADED;
    end else begin
      res.status = ST_LOCKED;
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] result word %0d: %s expected %0d, got %0d",
               $time, results_seen, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    ema_word_t want;
    if (!rst_n) begin
      regs_q      = '{gain: GAIN_RST, cap: CAP_RST, floor: FLOOR_RST, limit: LIMIT_RST};
      smooth_q    = '0;
      updates_q   = '0;
      last_conf_q = '0;
      predicted_words.delete();
    end else begin
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_IDX_GAIN:  regs_q.gain  = cfg_wdata[GAIN_W-1:0];
          CFG_IDX_CAP:   regs_q.cap   = cfg_wdata[CAP_W-1:0];
          CFG_IDX_FLOOR: regs_q.floor = cfg_wdata[CONF_W-1:0];
          CFG_IDX_LIMIT: regs_q.limit = cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      // Results leave at a later edge than the one that takes their input word, so the
      // output side is checked before this edge's input word is queued.
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        results_seen++;
        if (predicted_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] result word %0d arrived with none expected: acc %0b off %0d st %0d",
                     $time, results_seen, out_ch.accepted, out_ch.smoothed_offset,
                     out_ch.lock_status);
          end
        end else begin
          want = predicted_words.pop_front();
          if (out_ch.accepted !== want.accepted) begin
            flag_mismatch("accepted", want.accepted, out_ch.accepted);
          end
          if (out_ch.smoothed_offset !== want.offset) begin
            flag_mismatch("smoothed_offset", want.offset, out_ch.smoothed_offset);
          end
          if (out_ch.lock_status !== want.status) begin
            flag_mismatch("lock_status", want.status, out_ch.lock_status);
          end
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        predicted_words.push_back(smooth_word(in_ch.raw_offset, in_ch.confidence,
                                              in_ch.sample_invalid));
      end
    end
    mismatch_count  <= mismatches;
    pending_results <= predicted_words.size();
    checked_results <= results_seen;
  end

endmodule

FILE: tb/gated_slew_limited_ema_smoother_tb.sv
`timescale 1ns / 1ps

module gated_slew_limited_ema_smoother_tb;
  import gslema_pkg::*;

  localparam int OFFSET_BITS  = 24;
  localparam int RANDOM_WORDS = 1400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic signed [OFFSET_BITS-1:0] RAW_MAX = {1'b0, {(OFFSET_BITS-1){1'b1}}};
  localparam logic signed [OFFSET_BITS-1:0] RAW_MIN = {1'b1, {(OFFSET_BITS-1){1'b0}}};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int                    mismatch_count;
  int                    pending_results;
  int                    checked_results;
  int                    cycle_count = 0;
  int                    words_sent = 0;
  int                    invalid_sent = 0;
  int                    settings_written = 0;
  int                    send_idle_pct = 16;
  int                    recv_idle_pct = 75;
  logic [CONF_W-1:0]     cur_floor = FLOOR_RST;

  gslema_in_if  #(.OFFSET_BITS(OFFSET_BITS)) in_ch ();
  gslema_out_if #(.OFFSET_BITS(OFFSET_BITS)) out_ch ();

  gated_slew_limited_ema_smoother #(.OFFSET_BITS(OFFSET_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  gslema_output_checker #(.OFFSET_BITS(OFFSET_BITS)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .checked_results (checked_results)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results);
      $display("gated_slew_limited_ema_smoother_tb: FAIL");
      $finish;
    end
  end

  // Offers one word, with random idle cycles ahead of it, and returns after the
  // first edge past which ready reads high. Valid stays high so a following word
  // can go out back to back.
  task automatic send_word(input logic signed [OFFSET_BITS-1:0] raw,
                           input logic [CONF_W-1:0] conf, input logic inv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.raw_offset     <= raw;
    in_ch.confidence     <= conf;
    in_ch.sample_invalid <= inv;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) begin
      @(posedge clk);
    end
    words_sent++;
    if (inv) begin
      invalid_sent++;
    end
  endtask

  // Holds the input off until every outstanding result has been seen.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [GAIN_W-1:0] gain, input logic [CAP_W-1:0] cap,
                              input logic [CONF_W-1:0] flr, input logic [LIMIT_W-1:0] lim);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_ADDR_W-1:0] idxs [4];
    vals[0] = CFG_DATA_W'(gain);
    vals[1] = CFG_DATA_W'(cap);
    vals[2] = CFG_DATA_W'(flr);
    vals[3] = CFG_DATA_W'(lim);
    idxs[0] = CFG_IDX_GAIN;
    idxs[1] = CFG_IDX_CAP;
    idxs[2] = CFG_IDX_FLOOR;
    idxs[3] = CFG_IDX_LIMIT;
    drain_results();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    cur_floor = flr;
    settings_written++;
  endtask

  task automatic program_random_regs();
    logic [GAIN_W-1:0]  gain;
    logic [CAP_W-1:0]   cap;
    logic [CONF_W-1:0]  flr;
    logic [LIMIT_W-1:0] lim;
    case ($urandom_range(0, 4))
      0:       gain = '0;
      1:       gain = '1;
      2:       gain = GAIN_RST;
      default: gain = GAIN_W'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       cap = '0;
      1:       cap = '1;
      2:       cap = CAP_RST;
      3, 4:    cap = CAP_W'($urandom_range(1, 40000));
      default: cap = CAP_W'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       flr = '0;
      1:       flr = '1;
      2:       flr = FLOOR_RST;
      default: flr = CONF_W'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       lim = '0;
      1:       lim = '1;
      2:       lim = LIMIT_RST;
      3, 4:    lim = LIMIT_W'($urandom_range(0, 100000));
      default: lim = LIMIT_W'($urandom);
    endcase
    program_regs(gain, cap, flr, lim);
  endtask

  // Mostly valid words whose confidence sits at or above the floor, so the
  // filter keeps updating; the rest are invalid or rejected words.
  task automatic run_random_block(input int count);
    logic signed [OFFSET_BITS-1:0] raw;
    logic [CONF_W-1:0]             conf;
    logic                          inv;
    for (int n = 0; n < count; n++) begin
      inv = ($urandom_range(0, 99) < 8);
      case ($urandom_range(0, 9))
        0:       raw = RAW_MAX;
        1:       raw = RAW_MIN;
        2, 3, 4: raw = OFFSET_BITS'($urandom_range(0, 4000)) - OFFSET_BITS'(2000);
        default: raw = OFFSET_BITS'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0:       conf = cur_floor;
        1:       conf = cur_floor - 1'b1;
        2:       conf = '1;
        3:       conf = '0;
        8, 9:    conf = CONF_W'($urandom);
        default: conf = CONF_W'($urandom_range(cur_floor, 16'hFFFF));
      endcase
      send_word(raw, conf, inv);
    end
  endtask

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.raw_offset     = '0;
    in_ch.confidence     = '0;
    in_ch.sample_invalid = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: invalid words, the confidence floor edge, the slew cap
    // and the walk through not ready, locked and degraded.
    send_word(RAW_MAX, '1, 1'b1);
    send_word(24'sd1000, FLOOR_RST - 1'b1, 1'b0);
    send_word(RAW_MAX, FLOOR_RST, 1'b0);
    send_word(RAW_MIN, '1, 1'b0);
    send_word('0, FLOOR_RST, 1'b0);
    send_word(24'sd100, 16'd600, 1'b0);
    send_word('0, 16'd100, 1'b0);
    send_word(RAW_MIN, '0, 1'b1);

    // Full gain with the widest cap, floor zero and a zero alarm limit.
    program_regs('1, '1, '0, '0);
    send_word(RAW_MAX, '0, 1'b0);
    send_word(RAW_MIN, '0, 1'b0);
    send_word(24'sd1, '0, 1'b0);
    send_word('0, '0, 1'b0);
    send_word(-24'sd1, '0, 1'b0);

    // Zero gain and cap, top floor, widest alarm limit.
    program_regs('0, '0, '1, '1);
    send_word(RAW_MAX, '1, 1'b0);
    send_word(RAW_MIN, 16'hFFFE, 1'b0);
    send_word(24'sd5000, '1, 1'b0);

    // A zero cap freezes the offset while words are still accepted.
    program_regs(GAIN_RST, '0, '0, LIMIT_RST);
    send_word(RAW_MAX, '1, 1'b0);
    send_word(RAW_MIN, 16'h1234, 1'b0);

    program_regs(16'h8000, 23'd3, FLOOR_RST, 23'd10);
    send_word(24'sd1000, FLOOR_RST, 1'b0);
    send_word(-24'sd1000, FLOOR_RST, 1'b0);
    send_word(24'sd20, FLOOR_RST, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct <= 16;
          recv_idle_pct <= 75;
        end
        1: begin
          send_idle_pct <= 75;
          recv_idle_pct <= 16;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        program_random_regs();
        run_random_block(RANDOM_WORDS / 12);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d words (%0d invalid) over %0d register settings and three idle mixes;",
             words_sent, invalid_sent, settings_written);
    $display("checked %0d result words, %0d mismatches.", checked_results, mismatch_count);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("gated_slew_limited_ema_smoother_tb: PASS");
    end else begin
      $display("gated_slew_limited_ema_smoother_tb: FAIL");
    end
    $finish;
  end

endmodule
